// ===== hdl/ultrasonic_range_temp_compensated_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ULTRASONIC_RANGE_TEMP_COMPENSATED_MACROS_SVH
`define ULTRASONIC_RANGE_TEMP_COMPENSATED_MACROS_SVH

// Property checked every clock, off while in reset.
`define URTC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error("%m failed");

// Implication checked every clock, off while in reset.
`define URTC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) ante |-> cons) else $error("%m failed");

`endif

// ===== hdl/urtc_pkg.sv =====
// Types and constants of the compensated ultrasonic ranging block.
package urtc_pkg;

  localparam int unsigned SpeedSqBase = 109561;
  localparam int unsigned TempBase    = 4368;
  localparam int unsigned RangeDiv    = 512000;
  localparam int unsigned RawMax      = 4095;
  localparam int unsigned CalPoints   = 8;
  localparam int unsigned CalIdxW     = $clog2(CalPoints);

  // 65536 / 4368 == 4096 / 273, so the squared speed is (base * factor) * 4096 / 273
  localparam int unsigned SqShift  = 12;
  localparam int unsigned SqDiv    = TempBase >> 4;
  localparam int unsigned RcpSqK   = 30;
  localparam int unsigned RcpSq    = (1 << RcpSqK) / SqDiv;
  // 512000 == 125 << 12
  localparam int unsigned RangeShift = 12;
  localparam int unsigned RngDivLo   = RangeDiv >> RangeShift;
  localparam int unsigned RcpRngK    = 24;
  localparam int unsigned RcpRng     = (1 << RcpRngK) / RngDivLo;

  localparam int unsigned NumW   = 30;  // base * factor
  localparam int unsigned QhW    = 22;  // (base * factor) / 273
  localparam int unsigned DvsW   = 10;  // calibration divisor
  localparam int unsigned SqW    = 34;  // squared speed
  localparam int unsigned SpeedW = 17;  // Q8 speed
  localparam int unsigned ProdW  = 33;  // ticks * speed
  localparam int unsigned RngW   = ProdW - RangeShift;
  localparam int unsigned RcpW   = 18;  // width of the range reciprocal
  localparam int unsigned RqW    = 15;  // range quotient before saturation
  localparam int unsigned CalPW  = 20;  // dy * offset

  localparam logic [11:0] CAL_IN [CalPoints] =
    '{12'd27, 12'd45, 12'd90, 12'd136, 12'd181, 12'd226, 12'd272, 12'd726};
  localparam logic [9:0] CAL_OUT [CalPoints] =
    '{10'd30, 10'd50, 10'd100, 10'd150, 10'd200, 10'd250, 10'd300, 10'd800};

  typedef struct packed {
    logic [1:0]      sensor;
    logic [15:0]     ticks;
    logic [NumW-1:0] num;
  } job_t;

endpackage

// ===== hdl/urtc_in_if.sv =====
// Input word channel.
interface urtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  sensor_index;
  logic [15:0] echo_ticks;
  logic signed [11:0] temp_raw;

  modport source (output valid, sensor_index, echo_ticks, temp_raw, input ready);
  modport sink (input valid, sensor_index, echo_ticks, temp_raw, output ready);
endinterface

// ===== hdl/urtc_out_if.sv =====
// Result word channel.
interface urtc_out_if;
  logic       valid;
  logic       ready;
  logic [11:0] raw_range;
  logic [9:0]  calibrated_range;
  logic        sensor_alarm;
  logic        buzzer_on;

  modport source (output valid, raw_range, calibrated_range, sensor_alarm, buzzer_on,
                  input ready);
  modport sink (input valid, raw_range, calibrated_range, sensor_alarm, buzzer_on,
                output ready);
  modport mon (input valid, ready, raw_range, calibrated_range, sensor_alarm, buzzer_on);
endinterface

// ===== hdl/urtc_cfg_if.sv =====
// Configuration write channel.
interface urtc_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] alarm_threshold;

  modport source (output valid, alarm_threshold, input ready);
  modport sink (input valid, alarm_threshold, output ready);
endinterface

// ===== hdl/ultrasonic_range_temp_compensated.sv =====
// Top level of the temperature compensated ultrasonic ranging block.
//
//   channel  dir  fields
//   cfg_i    in   alarm_threshold
//   in_i     in   sensor_index, echo_ticks, temp_raw
//   out_o    out  raw_range, calibrated_range, sensor_alarm, buzzer_on
//
// One word holds the back end until its result is loaded: it takes the job, forms the
// squared speed (two reciprocal divide-by-273 passes), takes the square root, forms
// the range product and divide, does the table lookup, runs the calibration division
// (skipped when the range is off the table) and loads the output word.
// A waiting output word holds the back end; the queue and front then fill and
// in_i.ready drops. Reset clears the alarm flags and sets the threshold to 25.
module ultrasonic_range_temp_compensated #(
  parameter int unsigned SENSOR_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urtc_cfg_if.sink   cfg_i,
  urtc_in_if.sink    in_i,
  urtc_out_if.source out_o
);
  import urtc_pkg::*;

  logic [8:0] thr_q;
  logic       f_vld, f_rdy, b_vld, b_rdy;
  job_t       f_job, b_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 9'd25;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.alarm_threshold;
    end
  end

  urtc_front u_front (
    .clk_i, .rst_ni, .in_i,
    .job_valid_o(f_vld), .job_ready_i(f_rdy), .job_o(f_job)
  );

  urtc_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_vld), .push_ready_o(f_rdy), .push_i(f_job),
    .pop_valid_o(b_vld), .pop_ready_i(b_rdy), .pop_o(b_job)
  );

  urtc_back #(.SENSOR_COUNT(SENSOR_COUNT)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(b_vld), .job_ready_o(b_rdy), .job_i(b_job),
    .thr_i(thr_q), .out_o
  );
endmodule

// ===== hdl/urtc_front.sv =====
// Front end: takes an input word and forms the squared-speed numerator.
module urtc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  urtc_in_if.sink         in_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output urtc_pkg::job_t  job_o
);
  import urtc_pkg::*;

  logic        vld_q;
  job_t        job_q;
  logic [13:0] fac_sum;
  logic [12:0] factor;
  logic [29:0] prod;

  assign fac_sum = 14'($signed({in_i.temp_raw[11], in_i.temp_raw}) + 14'sd4368);
  assign factor  = fac_sum[12:0];
  assign prod    = 30'(SpeedSqBase) * {17'd0, factor};

  assign in_i.ready  = !vld_q || job_ready_i;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        vld_q        <= 1'b1;
        job_q.sensor <= in_i.sensor_index;
        job_q.ticks  <= in_i.echo_ticks;
        job_q.num    <= prod;
      end else if (job_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end
endmodule

// ===== hdl/urtc_queue.sv =====
// Two-entry job queue between front and back.
module urtc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  urtc_pkg::job_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output urtc_pkg::job_t pop_o
);
  import urtc_pkg::*;

  job_t       mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end
endmodule

// ===== hdl/urtc_back.sv =====
// Back end: reciprocal dividers, square root, calibration and alarm flags.
module urtc_back #(
  parameter int unsigned SENSOR_COUNT = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  urtc_pkg::job_t job_i,
  input  logic [8:0]     thr_i,
  urtc_out_if.source     out_o
);
  import urtc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_EST, ST_SQ_FIX, ST_SQRT, ST_MUL, ST_RNG_EST, ST_RNG_FIX, ST_CAL,
    ST_DIV_CAL, ST_FINISH
  } state_e;

  state_e            state_q;
  logic [5:0]        cnt_q;
  logic [1:0]        sensor_q;
  logic [15:0]       ticks_q;
  logic [NumW-1:0]   num_q;
  logic [QhW-1:0]    qest_q, qhi_q;
  logic              lo_q;
  logic [RngW-1:0]   rz_q;
  logic [RqW-1:0]    rq_q;
  logic [CalPW-1:0]  dq_q;
  logic [DvsW-1:0]   drem_q, dvs_q;
  logic [SqW-1:0]    sx_q;
  logic [18:0]       srem_q;
  logic [SpeedW-1:0] root_q;
  logic [11:0]       raw_q;
  logic [9:0]        y0_q, cal_q;
  logic [SENSOR_COUNT-1:0] flags_q;
  logic              out_vld_q;

  logic [NumW+QhW-1:0] sq_est;
  logic [NumW:0]     sq_sub, sq_rem;
  logic              sq_ge;
  logic [QhW-1:0]    sq_quo;
  logic [8:0]        sq_left;
  logic [ProdW-1:0]  rng_prod;
  logic [RngW+RcpW-1:0] rng_est;
  logic [RngW:0]     rng_sub, rng_rem;
  logic              rng_ge;
  logic [RqW-1:0]    rng_quo;
  logic [DvsW:0]     rem_sh;
  logic              dge;
  logic [DvsW-1:0]   drem_nx;
  logic [CalPW-1:0]  dq_nx;
  logic [20:0]       sr_sh, trial;
  logic              sge;
  logic [18:0]       srem_nx;
  logic [SpeedW-1:0] root_nx;
  logic [CalIdxW-1:0] idx;
  logic [CalIdxW-1:0] idx_n;
  logic              below, above;
  logic [9:0]        dx, dy, off;
  logic [CalPW-1:0]  cal_prod;
  logic              alarm;
  logic              fire;
  logic [SENSOR_COUNT-1:0] flags_d;

  // divide by 273: reciprocal estimate, then one correction step
  assign sq_est  = (NumW+QhW)'(num_q) * (NumW+QhW)'(RcpSq);
  assign sq_sub  = (NumW+1)'(qest_q) * (NumW+1)'(SqDiv);
  assign sq_rem  = (NumW+1)'(num_q) - sq_sub;
  assign sq_ge   = sq_rem >= (NumW+1)'(SqDiv);
  assign sq_quo  = QhW'(qest_q + QhW'(sq_ge));
  assign sq_left = sq_ge ? 9'(sq_rem - (NumW+1)'(SqDiv)) : sq_rem[8:0];

  // divide by 125 after dropping the low 12 bits of the product
  assign rng_prod = ProdW'(ticks_q) * ProdW'(root_q);
  assign rng_est  = (RngW+RcpW)'(rz_q) * (RngW+RcpW)'(RcpRng);
  assign rng_sub  = (RngW+1)'(rq_q) * (RngW+1)'(RngDivLo);
  assign rng_rem  = (RngW+1)'(rz_q) - rng_sub;
  assign rng_ge   = rng_rem >= (RngW+1)'(RngDivLo);
  assign rng_quo  = RqW'(rq_q + RqW'(rng_ge));

  assign rem_sh  = {drem_q, dq_q[CalPW-1]};
  assign dge     = rem_sh >= {1'b0, dvs_q};
  assign drem_nx = dge ? DvsW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DvsW-1:0];
  assign dq_nx   = {dq_q[CalPW-2:0], dge};

  assign sr_sh   = {srem_q, sx_q[SqW-1:SqW-2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign sge     = sr_sh >= trial;
  assign srem_nx = sge ? 19'(sr_sh - trial) : sr_sh[18:0];
  assign root_nx = {root_q[SpeedW-2:0], sge};

  always_comb begin
    idx = '0;
    for (int j = 1; j < CalPoints - 1; j++) begin
      if (raw_q >= CAL_IN[j]) idx = CalIdxW'(j);
    end
  end
  assign idx_n    = CalIdxW'(idx + 1'b1);
  assign below    = raw_q < CAL_IN[0];
  assign above    = raw_q >= CAL_IN[CalPoints-1];
  assign dx       = 10'(CAL_IN[idx_n] - CAL_IN[idx]);
  assign dy       = 10'(CAL_OUT[idx_n] - CAL_OUT[idx]);
  assign off      = 10'(raw_q - CAL_IN[idx]);
  assign cal_prod = CalPW'(dy) * CalPW'(off);

  assign alarm = cal_q < {1'b0, thr_i};
  always_comb begin
    flags_d = flags_q;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      if (int'(sensor_q) == k) flags_d[k] = alarm;
    end
  end

  assign fire        = (state_q == ST_FINISH) && (!out_vld_q || out_o.ready);
  assign job_ready_o = state_q == ST_IDLE;
  assign out_o.valid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            sensor_q <= job_i.sensor;
            ticks_q  <= job_i.ticks;
            num_q    <= job_i.num;
            lo_q     <= 1'b0;
            state_q  <= ST_SQ_EST;
          end
        end
        ST_SQ_EST: begin
          qest_q  <= sq_est[RcpSqK +: QhW];
          state_q <= ST_SQ_FIX;
        end
        ST_SQ_FIX: begin
          if (!lo_q) begin
            qhi_q   <= sq_quo;
            num_q   <= NumW'({sq_left, {SqShift{1'b0}}});
            lo_q    <= 1'b1;
            state_q <= ST_SQ_EST;
          end else begin
            sx_q    <= {qhi_q, sq_quo[SqShift-1:0]};
            srem_q  <= '0;
            root_q  <= '0;
            cnt_q   <= 6'(SpeedW);
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          sx_q   <= {sx_q[SqW-3:0], 2'b00};
          srem_q <= srem_nx;
          root_q <= root_nx;
          cnt_q  <= 6'(cnt_q - 1'b1);
          if (cnt_q == 6'd1) state_q <= ST_MUL;
        end
        ST_MUL: begin
          rz_q    <= rng_prod[ProdW-1:RangeShift];
          state_q <= ST_RNG_EST;
        end
        ST_RNG_EST: begin
          rq_q    <= rng_est[RcpRngK +: RqW];
          state_q <= ST_RNG_FIX;
        end
        ST_RNG_FIX: begin
          raw_q   <= (rng_quo > RqW'(RawMax)) ? 12'(RawMax) : rng_quo[11:0];
          state_q <= ST_CAL;
        end
        ST_CAL: begin
          if (below) begin
            cal_q   <= CAL_OUT[0];
            state_q <= ST_FINISH;
          end else if (above) begin
            cal_q   <= CAL_OUT[CalPoints-1];
            state_q <= ST_FINISH;
          end else begin
            y0_q    <= CAL_OUT[idx];
            dq_q    <= cal_prod;
            drem_q  <= '0;
            dvs_q   <= dx;
            cnt_q   <= 6'(CalPW);
            state_q <= ST_DIV_CAL;
          end
        end
        ST_DIV_CAL: begin
          dq_q   <= dq_nx;
          drem_q <= drem_nx;
          cnt_q  <= 6'(cnt_q - 1'b1);
          if (cnt_q == 6'd1) begin
            cal_q   <= 10'(y0_q + dq_nx[9:0]);
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            flags_q                <= flags_d;
            out_o.raw_range        <= raw_q;
            out_o.calibrated_range <= cal_q;
            out_o.sensor_alarm     <= alarm;
            out_o.buzzer_on        <= |flags_d;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/urtc_checker.sv =====
// Port checker for the ranging block and its bind.
`include "ultrasonic_range_temp_compensated_macros.svh"

module urtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  urtc_out_if.source out_i
);
  `URTC_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_i.valid && !out_i.ready, ##1 (out_i.valid && $stable(out_i.calibrated_range)))
  `URTC_ASSERT_IMP(a_alarm_buzz, clk_i, rst_ni, out_i.valid && out_i.sensor_alarm, out_i.buzzer_on)
  `URTC_ASSERT_IMP(a_cal_bounds, clk_i, rst_ni, out_i.valid, (out_i.calibrated_range >= 10'd30 && out_i.calibrated_range <= 10'd800))
  `URTC_ASSERT_IMP(a_below_tab, clk_i, rst_ni, out_i.valid && out_i.raw_range < 12'd27, out_i.calibrated_range == 10'd30)
endmodule

bind ultrasonic_range_temp_compensated urtc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_i(out_o)
);

// ===== bench/ultrasonic_range_temp_compensated_test.sv =====
// Testbench for the temperature compensated ultrasonic ranging block.
`timescale 1ns / 1ps

module ultrasonic_range_temp_compensated_test;
  import urtc_pkg::*;

  localparam int unsigned NumSensors = 4;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 300;

  typedef struct {
    logic [11:0] raw_range;
    logic [9:0]  calibrated_range;
    logic        sensor_alarm;
    logic        buzzer_on;
  } range_word_t;

  class range_scoreboard;
    range_word_t  pending_ranges[$];
    logic [8:0]   threshold;
    logic [3:0]   alarm_flags;
    int unsigned  mismatches;

    function new();
      threshold = 9'd25;
      alarm_flags = '0;
      mismatches = 0;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic logic [9:0] table_correct(logic [11:0] x);
      logic [9:0] dy;
      logic [11:0] dx;
      if (x < CAL_IN[0]) return CAL_OUT[0];
      if (x >= CAL_IN[CalPoints-1]) return CAL_OUT[CalPoints-1];
      for (int i = 0; i < CalPoints - 1; i++) begin
        if (x >= CAL_IN[i] && x < CAL_IN[i+1]) begin
          dx = CAL_IN[i+1] - CAL_IN[i];
          dy = CAL_OUT[i+1] - CAL_OUT[i];
          return CAL_OUT[i] + 10'((32'(dy) * 32'(x - CAL_IN[i])) / 32'(dx));
        end
      end
      return CAL_OUT[CalPoints-1];
    endfunction

    function void note_echo(logic [1:0] sensor, logic [15:0] ticks, logic signed [11:0] temp);
      range_word_t w;
      longint t;
      longint unsigned sq, speed, raw;
      t = temp;
      sq = (64'd109561 * 64'd65536 * longint'(4368 + t)) / 64'd4368;
      speed = floor_sqrt(sq);
      raw = (64'(ticks) * speed) / 64'd512000;
      if (raw > 4095) raw = 4095;
      w.raw_range = raw[11:0];
      w.calibrated_range = table_correct(raw[11:0]);
      w.sensor_alarm = (w.calibrated_range < 10'(threshold)) ? 1'b1 : 1'b0;
      if (sensor < NumSensors) alarm_flags[sensor] = w.sensor_alarm;
      w.buzzer_on = |alarm_flags;
      pending_ranges.push_back(w);
    endfunction

    function void check_range(range_word_t got);
      range_word_t exp_w;
      if (pending_ranges.size() == 0) begin
        $display("%0t: unexpected word raw=%0d cal=%0d", $realtime, got.raw_range,
                 got.calibrated_range);
        mismatches++;
        return;
      end
      exp_w = pending_ranges.pop_front();
      if (got.raw_range !== exp_w.raw_range) begin
        $display("%0t: raw_range exp %0d got %0d", $realtime, exp_w.raw_range, got.raw_range);
        mismatches++;
      end
      if (got.calibrated_range !== exp_w.calibrated_range) begin
        $display("%0t: calibrated_range exp %0d got %0d", $realtime,
                 exp_w.calibrated_range, got.calibrated_range);
        mismatches++;
      end
      if (got.sensor_alarm !== exp_w.sensor_alarm) begin
        $display("%0t: sensor_alarm exp %0b got %0b", $realtime, exp_w.sensor_alarm,
                 got.sensor_alarm);
        mismatches++;
      end
      if (got.buzzer_on !== exp_w.buzzer_on) begin
        $display("%0t: buzzer_on exp %0b got %0b", $realtime, exp_w.buzzer_on, got.buzzer_on);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  urtc_cfg_if cfg_ch();
  urtc_in_if  echo_ch();
  urtc_out_if range_ch();

  ultrasonic_range_temp_compensated dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .in_i   (echo_ch.sink),
    .out_o  (range_ch.source)
  );

  always #4 clk_i = ~clk_i;

  range_scoreboard sb = new();
  int unsigned cycles = 0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off.
  always @(posedge clk_i) begin
    range_word_t got;
    if (rst_ni && range_ch.valid && range_ch.ready) begin
      got.raw_range = range_ch.raw_range;
      got.calibrated_range = range_ch.calibrated_range;
      got.sensor_alarm = range_ch.sensor_alarm;
      got.buzzer_on = range_ch.buzzer_on;
      sb.check_range(got);
      hold_left = no_idle ? 0 : $urandom_range(0, 6);
    end
    if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left = 800;
    end
    if (hold_left > 0) begin
      range_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      range_ch.ready <= 1'b1;
    end
  end

  task automatic send_echo(logic [1:0] sensor, logic [15:0] ticks, logic signed [11:0] temp);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      echo_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    echo_ch.valid <= 1'b1;
    echo_ch.sensor_index <= sensor;
    echo_ch.echo_ticks <= ticks;
    echo_ch.temp_raw <= temp;
    do @(posedge clk_i); while (!echo_ch.ready);
    sb.note_echo(sensor, ticks, temp);
  endtask

  task automatic drain();
    echo_ch.valid <= 1'b0;
    while (sb.pending_ranges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [8:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.alarm_threshold <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.threshold = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_echo();
    logic [15:0] ticks;
    logic signed [11:0] temp;
    case ($urandom_range(0, 9))
      0: ticks = 16'($urandom);
      1: ticks = 16'($urandom_range(0, 200));
      default: ticks = 16'($urandom_range(0, 5200));
    endcase
    if ($urandom_range(0, 4) == 0) temp = 12'($urandom);
    else temp = 12'($signed($urandom_range(0, 2880)) - 880);
    send_echo(2'($urandom), ticks, temp);
  endtask

  initial begin
    logic [8:0] thresholds[6];
    thresholds = '{9'd0, 9'd511, 9'd2, 9'd400, 9'd150, 9'd300};
    rst_ni = 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.alarm_threshold <= '0;
    echo_ch.valid <= 1'b0;
    echo_ch.sensor_index <= '0;
    echo_ch.echo_ticks <= '0;
    echo_ch.temp_raw <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, table ends and breakpoints, reset threshold.
    send_echo(2'd0, 16'd0, 12'sd0);
    send_echo(2'd1, 16'd65535, 12'sd2047);
    send_echo(2'd2, 16'd65535, -12'sd2048);
    send_echo(2'd3, 16'd100, -12'sd880);
    send_echo(2'd0, 16'd163, 12'sd2000);
    send_echo(2'd1, 16'd165, 12'sd320);
    send_echo(2'd2, 16'd272, 12'sd320);
    send_echo(2'd3, 16'd544, 12'sd320);
    send_echo(2'd0, 16'd1640, 12'sd320);
    send_echo(2'd1, 16'd4380, 12'sd320);
    send_echo(2'd2, 16'd4395, 12'sd320);
    send_echo(2'd3, 16'd24700, 12'sd320);
    send_echo(2'd0, 16'd4387, 12'sd0);
    send_echo(2'd1, 16'd10, 12'sd0);
    send_echo(2'd1, 16'd3000, 12'sd0);
    send_echo(2'd3, 16'hAAAA, 12'h555);
    send_echo(2'd2, 16'h5555, 12'hAAA);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(thresholds[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 10) long_hold_req <= 1'b1;
        send_random_echo();
      end
      drain();
    end
    no_idle = 1'b0;
    write_threshold(9'($urandom_range(2, 400)));
    for (int n = 0; n < 40; n++) send_random_echo();
    drain();

    if (sb.mismatches == 0 && sb.pending_ranges.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
